// ----- src/scr_pkg.sv -----
// shared types and constants for the shape collision resolve unit
package scr_pkg;

  localparam int CW = 24;
  localparam int SZW = 20;
  localparam int GW = 8;
  localparam int OFFW = 22;
  localparam int SQW = 2 * (SZW + 1);
  localparam int PW = CW + SZW + 2;
  localparam int QDEPTH = 4;
  localparam int QPW = 2;
  localparam int LIM_BIT = 21;

  localparam logic [GW-1:0] GAP_RESET = 8'd3;

  // pair kinds, self first
  localparam logic [1:0] KIND_CC = 2'd0;
  localparam logic [1:0] KIND_CR = 2'd1;
  localparam logic [1:0] KIND_RC = 2'd2;
  localparam logic [1:0] KIND_RR = 2'd3;

  typedef struct packed {
    logic [1:0] pair_kind;
    logic signed [CW-1:0] self_x;
    logic signed [CW-1:0] self_y;
    logic [SZW-1:0] self_w;
    logic [SZW-1:0] self_h;
    logic signed [CW-1:0] other_x;
    logic signed [CW-1:0] other_y;
    logic [SZW-1:0] other_w;
    logic [SZW-1:0] other_h;
  } in_t;

  typedef struct packed {
    logic collided;
    logic signed [CW-1:0] new_x;
    logic signed [CW-1:0] new_y;
    logic moved;
  } out_t;

  // classified word passed from front to back
  typedef struct packed {
    logic [1:0] kind;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic dxneg;
    logic dyneg;
    logic rhit;
    logic lim;
    logic [SZW:0] wsum;
    logic [SZW:0] hsum;
    logic [SQW-1:0] dx2;
    logic [SQW-1:0] dy2;
    logic [SQW-1:0] ws2;
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic [SQW-1:0] magx;
    logic [SQW-1:0] magy;
  } q_t;

endpackage

// ----- src/scr_front.sv -----
// front end: takes words, classifies them and queues them for the back end
module scr_front (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  scr_pkg::in_t item,
  output logic busy,
  output scr_pkg::q_t head,
  output logic head_valid,
  input  logic pop
);
  import scr_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic [CW:0] adx;
    logic [CW:0] ady;
    logic dxneg;
    logic dyneg;
    logic rhit;
    logic lim;
    logic [SZW:0] wsum;
    logic [SZW:0] hsum;
    logic [SZW:0] wcmp;
    logic [SZW:0] hcmp;
  } s1_t;

  s1_t s1, s1_next;
  logic v1, v2;
  q_t s2, s2_next;
  q_t mem [QDEPTH];
  logic [QPW-1:0] wp, rp;
  logic [QPW:0] cnt;
  logic accept;

  logic signed [CW:0] dx, dy;
  logic self_circle, other_circle;
  logic [SZW:0] ax, ay, bx, by;

  assign accept = start && !busy;
  assign busy = ({1'b0, cnt} + {{(QPW+1){1'b0}}, v1} + {{(QPW+1){1'b0}}, v2})
                >= (QPW + 2)'(QDEPTH);

  // differences, extents and the rectangle overlap test
  always_comb begin
    dx = {item.other_x[CW-1], item.other_x} - {item.self_x[CW-1], item.self_x};
    dy = {item.other_y[CW-1], item.other_y} - {item.self_y[CW-1], item.self_y};
    self_circle = (item.pair_kind == KIND_CC) || (item.pair_kind == KIND_CR);
    other_circle = (item.pair_kind == KIND_CC) || (item.pair_kind == KIND_RC);
    ax = {1'b0, item.self_w};
    ay = self_circle ? {1'b0, item.self_w} : {1'b0, item.self_h};
    bx = {1'b0, item.other_w};
    by = other_circle ? {1'b0, item.other_w} : {1'b0, item.other_h};
    s1_next.kind = item.pair_kind;
    s1_next.sx = item.self_x;
    s1_next.sy = item.self_y;
    s1_next.ox = item.other_x;
    s1_next.oy = item.other_y;
    s1_next.dxneg = dx[CW];
    s1_next.dyneg = dy[CW];
    s1_next.adx = dx[CW] ? (~dx + 1'b1) : dx;
    s1_next.ady = dy[CW] ? (~dy + 1'b1) : dy;
    s1_next.rhit = ({s1_next.adx, 1'b0} <= (CW + 2)'(ax + bx))
                && ({s1_next.ady, 1'b0} <= (CW + 2)'(ay + by));
    s1_next.lim = (|s1_next.adx[CW:LIM_BIT]) || (|s1_next.ady[CW:LIM_BIT]);
    s1_next.wsum = bx + ax;
    s1_next.hsum = {1'b0, item.other_h} + ay;
    s1_next.wcmp = (item.pair_kind == KIND_CR) ? bx : s1_next.wsum;
    s1_next.hcmp = (item.pair_kind == KIND_CR) ? {1'b0, item.other_h} : s1_next.hsum;
  end

  // products for the axis choice and the circle path
  always_comb begin
    s2_next.kind = s1.kind;
    s2_next.sx = s1.sx;
    s2_next.sy = s1.sy;
    s2_next.ox = s1.ox;
    s2_next.oy = s1.oy;
    s2_next.dxneg = s1.dxneg;
    s2_next.dyneg = s1.dyneg;
    s2_next.rhit = s1.rhit;
    s2_next.lim = s1.lim;
    s2_next.wsum = s1.wsum;
    s2_next.hsum = s1.hsum;
    s2_next.px = s1.adx * s1.hcmp;
    s2_next.py = s1.ady * s1.wcmp;
    s2_next.dx2 = s1.adx[LIM_BIT-1:0] * s1.adx[LIM_BIT-1:0];
    s2_next.dy2 = s1.ady[LIM_BIT-1:0] * s1.ady[LIM_BIT-1:0];
    s2_next.ws2 = s1.wsum * s1.wsum;
    s2_next.magx = s1.adx[LIM_BIT-1:0] * s1.wsum;
    s2_next.magy = s1.ady[LIM_BIT-1:0] * s1.wsum;
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    s1 <= s1_next;
    s2 <= s2_next;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  // word queue
  always_ff @(posedge clk) begin
    if (v2) begin
      mem[wp] <= s2;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (v2) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + {{QPW{1'b0}}, v2} - {{QPW{1'b0}}, pop};
    end
  end

  assign head = mem[rp];
  assign head_valid = (cnt != '0);

endmodule

// ----- src/scr_back.sv -----
// back end: resolves queued words, with a shared root and divide unit for circle pairs
module scr_back (
  input  logic clk,
  input  logic rst,
  input  logic [scr_pkg::GW-1:0] gap,
  input  scr_pkg::q_t head,
  input  logic head_valid,
  output logic pop,
  output logic done,
  output scr_pkg::out_t result
);
  import scr_pkg::*;

  localparam int VW = CW + 2;
  localparam int NW = 60;
  localparam int RW = 53;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROOT = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;

  logic [1:0] st;
  logic [4:0] cnt;
  q_t e;
  logic [NW-1:0] rn, rr, rbit;
  logic [NW:0] rsum;
  logic rge;
  logic [NW-1:0] rn_next, rr_next;
  logic [RW-1:0] remx, remy, dsh;
  logic [OFFW-1:0] qx, qy, qx_next, qy_next;
  logic gex, gey;
  logic [SQW:0] d2;
  logic cc_hit;
  logic xsel;
  logic [OFFW-1:0] offw, offh;
  logic signed [CW-1:0] rx, ry;

  // move o by off toward the side given by neg, then saturate
  function automatic logic signed [CW-1:0] move_sat(input logic neg,
                                                    input logic signed [CW-1:0] o,
                                                    input logic [OFFW-1:0] off);
    logic signed [VW-1:0] v;
    logic signed [CW-1:0] r;
    v = neg ? ({{2{o[CW-1]}}, o} + {{(VW-OFFW){1'b0}}, off})
            : ({{2{o[CW-1]}}, o} - {{(VW-OFFW){1'b0}}, off});
    if ((&v[VW-1:CW-1]) || !(|v[VW-1:CW-1])) begin
      r = v[CW-1:0];
    end else if (v[VW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  assign pop = (st == S_IDLE) && head_valid;

  // circle pair overlap and rectangle push-out from the queue head
  always_comb begin
    d2 = {1'b0, head.dx2} + {1'b0, head.dy2};
    cc_hit = !head.lim && ({d2, 2'b00} < {3'b000, head.ws2});
    xsel = !(head.px < head.py);
    offw = OFFW'((head.wsum + 1'b1) >> 1) + {{(OFFW-GW){1'b0}}, gap};
    offh = OFFW'((head.hsum + 1'b1) >> 1) + {{(OFFW-GW){1'b0}}, gap};
    rx = head.sx;
    ry = head.sy;
    if (head.rhit && head.kind != KIND_RC) begin
      if (xsel) begin
        rx = move_sat(head.dxneg, head.ox, offw);
      end else begin
        ry = move_sat(head.dyneg, head.oy, offh);
      end
    end
  end

  // one root bit per cycle
  always_comb begin
    rsum = {1'b0, rr} + {1'b0, rbit};
    rge = {1'b0, rn} >= rsum;
    rn_next = rge ? (rn - rsum[NW-1:0]) : rn;
    rr_next = rge ? ((rr >> 1) + rbit) : (rr >> 1);
  end

  // one quotient bit per cycle on each axis
  always_comb begin
    gex = remx >= dsh;
    gey = remy >= dsh;
    qx_next = {qx[OFFW-2:0], gex};
    qy_next = {qy[OFFW-2:0], gey};
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (head_valid) begin
            if (head.kind != KIND_CC) begin
              done <= 1'b1;
              result.collided <= head.rhit;
              result.new_x <= rx;
              result.new_y <= ry;
              result.moved <= (rx != head.sx) || (ry != head.sy);
            end else if (cc_hit && (d2 != '0)) begin
              e <= head;
              rn <= {1'b0, d2, 16'b0};
              rr <= '0;
              rbit <= NW'(1) << (NW - 2);
              cnt <= 5'd29;
              st <= S_ROOT;
            end else begin
              done <= 1'b1;
              result.collided <= cc_hit;
              result.new_x <= head.sx;
              result.new_y <= head.sy;
              result.moved <= 1'b0;
            end
          end
        end
        S_ROOT: begin
          rn <= rn_next;
          rr <= rr_next;
          rbit <= rbit >> 2;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            remx <= {3'b000, e.magx, 8'b0} + {22'b0, rr_next[30:0]};
            remy <= {3'b000, e.magy, 8'b0} + {22'b0, rr_next[30:0]};
            dsh <= {rr_next[30:0], 22'b0};
            qx <= '0;
            qy <= '0;
            cnt <= 5'd21;
            st <= S_DIV;
          end
        end
        S_DIV: begin
          remx <= gex ? (remx - dsh) : remx;
          remy <= gey ? (remy - dsh) : remy;
          qx <= qx_next;
          qy <= qy_next;
          dsh <= dsh >> 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            done <= 1'b1;
            result.collided <= 1'b1;
            result.new_x <= move_sat(e.dxneg, e.ox, qx_next);
            result.new_y <= move_sat(e.dyneg, e.oy, qy_next);
            result.moved <= (move_sat(e.dxneg, e.ox, qx_next) != e.sx)
                         || (move_sat(e.dyneg, e.oy, qy_next) != e.sy);
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/shape_collision_resolve_unit.sv -----
// top level of the shape collision resolve unit
// Tests a pair of shapes (circle or rectangle) for overlap and gives self's pushed-out
// position. A word is taken when start is high and busy is low; each result shows on
// result for one cycle with done high and cannot be held off. A two-stage front end
// classifies words into a four-word queue. Pairs with a rectangle leave the back end
// one per cycle while the back end is idle, passing the two front stages, the queue
// and the result register. A colliding circle pair with distinct centres holds the
// back end through the one-bit-per-cycle square root and divide unit; other circle
// pairs resolve from idle. busy rises while the queue and front end hold four words.
module shape_collision_resolve_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  scr_pkg::in_t item,
  output logic done,
  output scr_pkg::out_t result,
  input  logic cfg_we,
  input  logic [scr_pkg::GW-1:0] cfg_data
);
  import scr_pkg::*;

  logic [GW-1:0] push_gap;
  q_t head;
  logic head_valid;
  logic pop;

  // push gap register
  always_ff @(posedge clk) begin
    if (rst) begin
      push_gap <= GAP_RESET;
    end else if (cfg_we) begin
      push_gap <= cfg_data;
    end
  end

  scr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .busy       (busy),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  scr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .gap        (push_gap),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .done       (done),
    .result     (result)
  );

endmodule
